// ----- hdl/imu_bcc_pkg.sv -----
// Shared types, constants and helper functions of the IMU bias calibrate and correct block
`timescale 1ns / 1ps

package imu_bcc_pkg;

  // Axis layout: accel x, y, z then gyro x, y, z
  localparam int AXES      = 6;
  localparam int AXIS_W    = $clog2(AXES);
  localparam int RAW_W     = 16;
  localparam int SUM_W     = 33;
  localparam int AVG_W     = 32;
  localparam int ACC_OUT_W = 25;
  localparam int GYR_OUT_W = 20;
  localparam int DEN_W     = 16;
  localparam int WIDE_W    = 48;

  // One g on the z accel, in raw counts
  localparam int ONE_G = 4096;

  // Calibration run length after reset
  localparam logic [DEN_W-1:0] COUNT_RESET = 16'd64;

  // Gyro scaling: multiply by 31970 (about 2^20 / 32.8), then round off 20 bits
  localparam int GYRO_RECIP_W = 16;
  localparam logic [GYRO_RECIP_W-1:0] GYRO_RECIP = 16'd31970;
  localparam int GS_DIG_W  = 4;
  localparam int GS_DIGITS = GYRO_RECIP_W / GS_DIG_W;
  localparam int GS_SHIFT  = 20;
  localparam int GS_PROD_W = AVG_W + GYRO_RECIP_W;
  localparam int GS_Q_W    = GS_PROD_W - GS_SHIFT + 1;

  typedef logic signed [RAW_W-1:0]     raw_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [AVG_W-1:0]     avg_t;
  typedef logic signed [ACC_OUT_W-1:0] acc_out_t;
  typedef logic signed [GYR_OUT_W-1:0] gyr_out_t;
  typedef logic signed [GS_Q_W-1:0]    gs_q_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_FINISH
  } state_t;

  // Clamp to the accel output / bias range
  function automatic acc_out_t sat_acc(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (ACC_OUT_W - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return acc_out_t'(hi);
    end else if (v < lo) begin
      return acc_out_t'(lo);
    end
    return acc_out_t'(v);
  endfunction

  // Clamp to the gyro output range
  function automatic gyr_out_t sat_gyr(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (GYR_OUT_W - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return gyr_out_t'(hi);
    end else if (v < lo) begin
      return gyr_out_t'(lo);
    end
    return gyr_out_t'(v);
  endfunction

  // One hex digit of the gyro reciprocal, digit 0 is the least significant
  function automatic logic [GS_DIG_W-1:0] gyro_digit(input int idx);
    return GYRO_RECIP[idx*GS_DIG_W +: GS_DIG_W];
  endfunction

endpackage

// ----- hdl/imu_bcc_in_if.sv -----
// Input channel interface: one raw six-axis sample per word
`timescale 1ns / 1ps

interface imu_bcc_in_if;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  imu_bcc_pkg::raw_t       accel_x_raw;
  imu_bcc_pkg::raw_t       accel_y_raw;
  imu_bcc_pkg::raw_t       accel_z_raw;
  imu_bcc_pkg::raw_t       gyro_x_raw;
  imu_bcc_pkg::raw_t       gyro_y_raw;
  imu_bcc_pkg::raw_t       gyro_z_raw;

  modport source (
    output valid, mode, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );

  modport sink (
    input  valid, mode, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

// ----- hdl/imu_bcc_out_if.sv -----
// Result channel interface: corrected sample or fresh biases per word
`timescale 1ns / 1ps

interface imu_bcc_out_if;
  logic                    valid;
  logic                    ready;
  imu_bcc_pkg::acc_out_t   accel_x_out;
  imu_bcc_pkg::acc_out_t   accel_y_out;
  imu_bcc_pkg::acc_out_t   accel_z_out;
  imu_bcc_pkg::gyr_out_t   gyro_x_out;
  imu_bcc_pkg::gyr_out_t   gyro_y_out;
  imu_bcc_pkg::gyr_out_t   gyro_z_out;
  logic                    calib_done;

  modport source (
    output valid, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out, calib_done,
    input  ready
  );

  modport sink (
    input  valid, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out, calib_done,
    output ready
  );
endinterface

// ----- hdl/imu_bcc_div.sv -----
// Bit-serial restoring divider: round(sum * 2^FRACTION_BITS / den), clamped to 32 bits
`timescale 1ns / 1ps

module imu_bcc_div #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  imu_bcc_pkg::sum_t                   num,
  input  logic [imu_bcc_pkg::DEN_W-1:0]       den,
  output logic                                done,
  output imu_bcc_pkg::avg_t                   q
);

  localparam int SUM_W = imu_bcc_pkg::SUM_W;
  localparam int AVG_W = imu_bcc_pkg::AVG_W;
  localparam int DEN_W = imu_bcc_pkg::DEN_W;
  localparam int NUM_W = SUM_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  work_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              fin_r;
  logic              done_r;
  imu_bcc_pkg::avg_t q_r;

  logic [SUM_W-1:0]  mag;
  logic [NUM_W-1:0]  dividend;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W-1:0]  rem_nxt;
  logic              ovf;
  logic [AVG_W-2:0]  qmag;

  // Magnitude of the scaled sum plus half the divisor for round half away from zero
  always_comb begin
    mag      = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    dividend = (NUM_W'(mag) << FRACTION_BITS) + NUM_W'(den >> 1);
  end

  // One quotient bit per cycle: shift in the next dividend bit, try to subtract
  always_comb begin
    trial   = {rem_r, work_r[NUM_W-1]};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
  end

  // Clamp the quotient magnitude to 31 bits
  always_comb begin
    ovf  = |work_r[NUM_W-1:AVG_W-1];
    qmag = ovf ? {(AVG_W-1){1'b1}} : work_r[AVG_W-2:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == '0)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Load, shift and finish the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
      den_r  <= den;
      neg_r  <= num[SUM_W-1];
      cnt_r  <= CNT_W'(NUM_W - 1);
    end else if (run_r) begin
      work_r <= {work_r[NUM_W-2:0], ge};
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - CNT_W'(1);
    end
    if (fin_r) begin
      q_r <= neg_r ? -imu_bcc_pkg::avg_t'({1'b0, qmag}) : imu_bcc_pkg::avg_t'({1'b0, qmag});
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- hdl/imu_bcc_gscale.sv -----
// Digit-serial gyro scaler: round(x * 31970 / 2^20), one hex digit of the constant per cycle
`timescale 1ns / 1ps

module imu_bcc_gscale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  imu_bcc_pkg::avg_t   x,
  output logic                done,
  output imu_bcc_pkg::gs_q_t  q
);

  localparam int AVG_W     = imu_bcc_pkg::AVG_W;
  localparam int DIG_W     = imu_bcc_pkg::GS_DIG_W;
  localparam int PROD_W    = imu_bcc_pkg::GS_PROD_W;
  localparam int SHIFT     = imu_bcc_pkg::GS_SHIFT;
  localparam int Q_W       = imu_bcc_pkg::GS_Q_W;
  localparam int PART_W    = AVG_W + DIG_W;
  localparam int CNT_W     = $clog2(imu_bcc_pkg::GS_DIGITS);

  logic [AVG_W-1:0]    mag_r;
  logic                neg_r;
  logic [PROD_W-1:0]   acc_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                run_r;
  logic                fin_r;
  logic                done_r;
  imu_bcc_pkg::gs_q_t  q_r;

  logic [DIG_W-1:0]    dig;
  logic [PART_W-1:0]   part;
  logic [PROD_W-1:0]   acc_nxt;
  logic [PROD_W-1:0]   rnd;
  logic [Q_W-2:0]      qmag;

  // Horner step, most significant digit first
  always_comb begin
    dig     = imu_bcc_pkg::gyro_digit(int'(cnt_r));
    part    = PART_W'(mag_r) * PART_W'(dig);
    acc_nxt = (acc_r << DIG_W) + PROD_W'(part);
  end

  // Round half away from zero on the magnitude, drop the fraction
  always_comb begin
    rnd  = acc_r + (PROD_W'(1) << (SHIFT - 1));
    qmag = rnd[PROD_W-1:SHIFT];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == '0)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Load, accumulate and finish
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= x[AVG_W-1] ? AVG_W'(-x) : AVG_W'(x);
      neg_r <= x[AVG_W-1];
      acc_r <= '0;
      cnt_r <= CNT_W'(imu_bcc_pkg::GS_DIGITS - 1);
    end else if (run_r) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (fin_r) begin
      q_r <= neg_r ? -imu_bcc_pkg::gs_q_t'({1'b0, qmag}) : imu_bcc_pkg::gs_q_t'({1'b0, qmag});
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- hdl/imu_bias_calibrate_correct.sv -----
// Top level of the six-axis IMU bias calibrate and correct block. One input word
// carries a raw sample; in measure mode the block returns the bias-corrected accel
// (counts, FRACTION_BITS fraction bits) and gyro (deg/s, FRACTION_BITS fraction
// bits), saturated; the time this takes is set by the three
// gyro scaling lanes, which multiply by 31970 one hex digit per cycle. A calibration
// word that does not close the run is summed and returns nothing. For the word
// that closes the run, one shared bit-serial divider forms the six averages one
// after another, one quotient bit per cycle, then the gyro lanes scale the gyro ones; the
// result carries the new biases with calib_done set. The block takes one word at
// a time; a finished result waits in the output register while the next word is
// accepted. cfg_wr_en writes sample_count (zero acts as one); write it only while
// idle, the block itself does not enforce this.
`timescale 1ns / 1ps

module imu_bias_calibrate_correct #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  imu_bcc_in_if.sink                       in_ch,
  imu_bcc_out_if.source                    out_ch,
  input  logic                             cfg_wr_en,
  input  logic [imu_bcc_pkg::DEN_W-1:0]    cfg_wr_data
);

  localparam int AXES   = imu_bcc_pkg::AXES;
  localparam int AXIS_W = imu_bcc_pkg::AXIS_W;
  localparam int DEN_W  = imu_bcc_pkg::DEN_W;
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  imu_bcc_pkg::state_t     state_r, state_nxt;

  // Captured sample
  logic                    mode_r;
  imu_bcc_pkg::raw_t       raw_r   [AXES];

  // Calibration state
  imu_bcc_pkg::sum_t       sum_r   [AXES];
  imu_bcc_pkg::acc_out_t   bias_r  [AXES];
  imu_bcc_pkg::avg_t       avg_r   [AXES];
  logic [DEN_W-1:0]        taken_r;
  logic [DEN_W-1:0]        count_r;
  logic [AXIS_W-1:0]       axis_r;

  // Output register
  logic                    out_valid_r;
  imu_bcc_pkg::acc_out_t   out_acc_r [3];
  imu_bcc_pkg::gyr_out_t   out_gyr_r [3];
  logic                    out_done_r;

  // Control
  logic                    in_ready;
  logic                    in_fire;
  logic                    out_free;
  logic                    out_load;
  logic                    div_start;
  logic                    gs_start;

  // Arithmetic
  imu_bcc_pkg::sum_t       sum_upd [AXES];
  logic [DEN_W-1:0]        taken_nxt;
  logic [DEN_W-1:0]        n_eff;
  logic                    run_done;

  logic                    div_done;
  imu_bcc_pkg::avg_t       div_q;

  imu_bcc_pkg::avg_t       gs_x    [3];
  imu_bcc_pkg::gs_q_t      gs_q    [3];
  logic [2:0]              gs_done;

  imu_bcc_pkg::acc_out_t   new_bias [AXES];
  imu_bcc_pkg::acc_out_t   acc_res  [3];
  imu_bcc_pkg::gyr_out_t   gyr_res  [3];

  assign in_fire  = in_ready && in_ch.valid;
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imu_bcc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.mode ? imu_bcc_pkg::ST_ACCUM : imu_bcc_pkg::ST_SCALE_GO;
        end
      end
      imu_bcc_pkg::ST_ACCUM: begin
        state_nxt = run_done ? imu_bcc_pkg::ST_DIV_GO : imu_bcc_pkg::ST_IDLE;
      end
      imu_bcc_pkg::ST_DIV_GO: begin
        state_nxt = imu_bcc_pkg::ST_DIV_WAIT;
      end
      imu_bcc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (axis_r == LAST_AXIS) ? imu_bcc_pkg::ST_SCALE_GO
                                            : imu_bcc_pkg::ST_DIV_GO;
        end
      end
      imu_bcc_pkg::ST_SCALE_GO: begin
        state_nxt = imu_bcc_pkg::ST_SCALE_WAIT;
      end
      imu_bcc_pkg::ST_SCALE_WAIT: begin
        if (&gs_done) begin
          state_nxt = imu_bcc_pkg::ST_FINISH;
        end
      end
      imu_bcc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = imu_bcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = imu_bcc_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    gs_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      imu_bcc_pkg::ST_IDLE:     in_ready  = 1'b1;
      imu_bcc_pkg::ST_DIV_GO:   div_start = 1'b1;
      imu_bcc_pkg::ST_SCALE_GO: gs_start  = 1'b1;
      imu_bcc_pkg::ST_FINISH:   out_load  = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Per-axis running sums, one g taken off the z accel
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sum_upd[i] = sum_r[i] + imu_bcc_pkg::sum_t'(raw_r[i]);
    end
    sum_upd[2] = sum_r[2] + imu_bcc_pkg::sum_t'(raw_r[2])
               - imu_bcc_pkg::sum_t'(imu_bcc_pkg::ONE_G);
    taken_nxt = taken_r + DEN_W'(1);
    n_eff     = (count_r == '0) ? DEN_W'(1) : count_r;
    run_done  = (taken_nxt >= n_eff);
  end

  // Shared divider for the six averages
  imu_bcc_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r[axis_r]),
    .den   (n_eff),
    .done  (div_done),
    .q     (div_q)
  );

  // Gyro scaling lanes: raw sample in measure mode, averages at the end of a run
  for (genvar g = 0; g < 3; g++) begin : g_gs
    assign gs_x[g] = mode_r ? avg_r[3+g]
                            : (imu_bcc_pkg::avg_t'(raw_r[3+g]) <<< FRACTION_BITS);

    imu_bcc_gscale u_gscale (
      .clk   (clk),
      .rst_n (rst_n),
      .start (gs_start),
      .x     (gs_x[g]),
      .done  (gs_done[g]),
      .q     (gs_q[g])
    );
  end

  // Corrected values and new biases
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      new_bias[i]   = imu_bcc_pkg::sat_acc(imu_bcc_pkg::wide_t'(avg_r[i]));
      new_bias[3+i] = imu_bcc_pkg::sat_acc(imu_bcc_pkg::wide_t'(gs_q[i]));
      if (mode_r) begin
        acc_res[i] = new_bias[i];
        gyr_res[i] = imu_bcc_pkg::sat_gyr(imu_bcc_pkg::wide_t'(new_bias[3+i]));
      end else begin
        acc_res[i] = imu_bcc_pkg::sat_acc(
                       (imu_bcc_pkg::wide_t'(raw_r[i]) <<< FRACTION_BITS)
                       - imu_bcc_pkg::wide_t'(bias_r[i]));
        gyr_res[i] = imu_bcc_pkg::sat_gyr(
                       imu_bcc_pkg::wide_t'(gs_q[i])
                       - imu_bcc_pkg::wide_t'(bias_r[3+i]));
      end
    end
  end

  // Control state, calibration state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imu_bcc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= imu_bcc_pkg::COUNT_RESET;
      taken_r     <= '0;
      for (int i = 0; i < AXES; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == imu_bcc_pkg::ST_ACCUM) begin
        taken_r <= run_done ? '0 : taken_nxt;
        for (int i = 0; i < AXES; i++) begin
          sum_r[i] <= sum_upd[i];
        end
      end
      // Commit the new biases and restart the sums when the run closes
      if (out_load && mode_r) begin
        for (int i = 0; i < AXES; i++) begin
          bias_r[i] <= new_bias[i];
          sum_r[i]  <= '0;
        end
      end
    end
  end

  // Capture the word, collect averages, load the output register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r   <= in_ch.mode;
      raw_r[0] <= in_ch.accel_x_raw;
      raw_r[1] <= in_ch.accel_y_raw;
      raw_r[2] <= in_ch.accel_z_raw;
      raw_r[3] <= in_ch.gyro_x_raw;
      raw_r[4] <= in_ch.gyro_y_raw;
      raw_r[5] <= in_ch.gyro_z_raw;
    end
    if (state_r == imu_bcc_pkg::ST_ACCUM) begin
      axis_r <= '0;
    end else if ((state_r == imu_bcc_pkg::ST_DIV_WAIT) && div_done) begin
      avg_r[axis_r] <= div_q;
      axis_r        <= axis_r + AXIS_W'(1);
    end
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_acc_r[i] <= acc_res[i];
        out_gyr_r[i] <= gyr_res[i];
      end
      out_done_r <= mode_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.accel_x_out = out_acc_r[0];
  assign out_ch.accel_y_out = out_acc_r[1];
  assign out_ch.accel_z_out = out_acc_r[2];
  assign out_ch.gyro_x_out  = out_gyr_r[0];
  assign out_ch.gyro_y_out  = out_gyr_r[1];
  assign out_ch.gyro_z_out  = out_gyr_r[2];
  assign out_ch.calib_done  = out_done_r;

endmodule

// ----- hdl/imu_bcc_checker.sv -----
// Port-level checker for the IMU bias calibrate and correct block, with its bind
`timescale 1ns / 1ps

module imu_bcc_port_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input imu_bcc_pkg::acc_out_t         out_accel_x,
  input imu_bcc_pkg::gyr_out_t         out_gyro_z,
  input logic                          out_calib_done
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // One word at a time: an accepted word closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after acceptance");

  // A new result only appears right after the input side was closed
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled output word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_accel_x) && $stable(out_gyro_z) && $stable(out_calib_done))
    else $error("stalled output word changed");

endmodule

bind imu_bias_calibrate_correct imu_bcc_port_props u_imu_bcc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_accel_x    (out_ch.accel_x_out),
  .out_gyro_z     (out_ch.gyro_z_out),
  .out_calib_done (out_ch.calib_done)
);
